// ===== src/mbrot_pkg.sv =====
// Shared types, constants and helpers of the escape-time pixel unit.
`default_nettype none

package mbrot_pkg;

  // Fixed field widths.
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned ITER_W    = 16;
  localparam int unsigned POWER_W   = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_X    = 3'd0,
    CFG_STEP_Y    = 3'd1,
    CFG_ORIGIN_X  = 3'd2,
    CFG_ORIGIN_Y  = 3'd3,
    CFG_ESCAPE_SQ = 3'd4,
    CFG_MAX_ITER  = 3'd5,
    CFG_POWER     = 3'd6
  } cfg_idx_t;

  // Current register contents, handed from the register file to the datapath.
  typedef struct packed {
    logic signed [WORD_W-1:0] step_x;
    logic signed [WORD_W-1:0] step_y;
    logic signed [WORD_W-1:0] origin_x;
    logic signed [WORD_W-1:0] origin_y;
    logic [WORD_W-1:0]        escape_sq;
    logic [ITER_W-1:0]        max_iter;
    logic [POWER_W-1:0]       power;
  } cfg_t;

  // Sequencer states. Each multiply takes an issue state (_M) and an
  // accumulate state (_A) that consumes the registered product.
  typedef enum logic [4:0] {
    S_IDLE,
    S_CRE_M,
    S_CRE_A,
    S_CIM_M,
    S_CIM_A,
    S_ITER,
    S_K0_M,
    S_K0_A,
    S_K1_M,
    S_K1_A,
    S_K2_M,
    S_K2_A,
    S_K3_M,
    S_K3_A,
    S_ADDC,
    S_MAG0_M,
    S_MAG0_A,
    S_MAG1_M,
    S_MAG1_A,
    S_TEST,
    S_DONE
  } state_t;

  // Saturate a 65-bit signed value to the signed 32-bit range.
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W:0] v);
    logic signed [WORD_W-1:0] r;
    if ((&v[PROD_W:WORD_W-1]) || !(|v[PROD_W:WORD_W-1])) begin
      r = v[WORD_W-1:0];
    end else if (v[PROD_W]) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/mbrot_mul.sv =====
// Shared signed 32 by 32 multiplier with a registered product.
`default_nettype none

module mbrot_mul
  import mbrot_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [WORD_W-1:0] a,
  input  wire logic signed [WORD_W-1:0] b,
  output logic signed [PROD_W-1:0]      prod
);

  // The full product is registered before anything uses it.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire

// ===== src/mbrot_cfg.sv =====
// Configuration register file of the escape-time pixel unit.
`default_nettype none

module mbrot_cfg
  import mbrot_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  output cfg_t                      cfg
);

  // Writes are always taken; an index beyond the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_x    <= '0;
      cfg.step_y    <= '0;
      cfg.origin_x  <= '0;
      cfg.origin_y  <= '0;
      cfg.escape_sq <= 32'h4000_0000;
      cfg.max_iter  <= 16'd256;
      cfg.power     <= 4'd2;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STEP_X:    cfg.step_x    <= cfg_data;
        CFG_STEP_Y:    cfg.step_y    <= cfg_data;
        CFG_ORIGIN_X:  cfg.origin_x  <= cfg_data;
        CFG_ORIGIN_Y:  cfg.origin_y  <= cfg_data;
        CFG_ESCAPE_SQ: cfg.escape_sq <= cfg_data;
        CFG_MAX_ITER:  cfg.max_iter  <= cfg_data[ITER_W-1:0];
        CFG_POWER:     cfg.power     <= cfg_data[POWER_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/mandelbrot_escape_time_pixel_unit.sv =====
// Escape-time pixel unit: maps a pixel to c and iterates z = z^power + c.
//
// Channels: the input channel takes one pixel (pixel_x, pixel_y) per transfer;
// the output channel gives one result (iterations, escaped, final_mag_sq) per
// pixel. The configuration channel writes one register per transfer and is
// always ready; it should only be written while no pixel is in progress.
// One pixel is worked on at a time, with a single shared multiplier under a
// sequencer; in_ready is high only while the sequencer is idle. Every product
// takes an issue state and an accumulate state. A pixel that escapes runs two
// extra iterations after the failing one before its magnitude is taken, and a
// limit of zero skips the iterations and goes straight to the result.
// The result sits in an output register, so a stalled receiver only holds the
// block once the next pixel is finished and cannot be written out.
// Synchronous reset returns the sequencer to idle, drops out_valid and loads
// the register defaults (escape_sq 4.0, max_iter 256, power 2, others zero).
`default_nettype none

module mandelbrot_escape_time_pixel_unit
  import mbrot_pkg::*;
#(
  parameter int MAX_POWER  = 8,
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COORD_BITS-1:0] pixel_x,
  input  wire logic [COORD_BITS-1:0] pixel_y,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ITER_W-1:0]          iterations,
  output logic                       escaped,
  output logic [WORD_W-1:0]          final_mag_sq,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [WORD_W-1:0]     cfg_data
);

  localparam int PW_BITS = $clog2(MAX_POWER + 1);
  localparam int MAG_W   = PROD_W + 1 - FRAC_BITS;

  cfg_t cfg;

  state_t state;
  state_t state_next;

  // Multiplier operands and product.
  logic signed [WORD_W-1:0] mul_a;
  logic signed [WORD_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_fl;

  // Datapath registers.
  logic [COORD_BITS-1:0]    px;
  logic [COORD_BITS-1:0]    py;
  logic signed [WORD_W-1:0] cr;
  logic signed [WORD_W-1:0] ci;
  logic signed [WORD_W-1:0] zr;
  logic signed [WORD_W-1:0] zi;
  logic signed [WORD_W-1:0] pr;
  logic signed [WORD_W-1:0] pi;
  logic signed [WORD_W-1:0] tr;
  logic signed [PROD_W-1:0] acc;
  logic [MAG_W-1:0]         mag;
  logic [ITER_W-1:0]        count;
  logic                     outside;
  logic                     extra;
  logic [PW_BITS-1:0]       p_eff;
  logic [PW_BITS-1:0]       kcnt;

  // Combinational helpers.
  logic [PW_BITS-1:0]       p_clamp;
  logic signed [PROD_W:0]   c_sum;
  logic signed [PROD_W:0]   re_sum;
  logic signed [PROD_W:0]   im_sum;
  logic [PROD_W:0]          sq_sum;
  logic signed [WORD_W:0]   addr_sum;
  logic signed [WORD_W:0]   addi_sum;
  logic                     mag_le;
  logic                     last_iter;
  logic                     out_load;
  logic [ITER_W-1:0]        count_inc;

  mbrot_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbrot_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Power zero acts as one; powers above the limit are clamped.
  always_comb begin
    if (cfg.power == '0) begin
      p_clamp = PW_BITS'(1);
    end else if (int'(cfg.power) > MAX_POWER) begin
      p_clamp = PW_BITS'(MAX_POWER);
    end else begin
      p_clamp = PW_BITS'(cfg.power);
    end
  end

  // Product rounded toward minus infinity, and the sums fed to saturation.
  assign prod_fl  = prod >>> FRAC_BITS;
  assign c_sum    = {prod[PROD_W-1], prod} +
                    {{(PROD_W+1-WORD_W){(state == S_CRE_A) ? cfg.origin_x[WORD_W-1]
                                                           : cfg.origin_y[WORD_W-1]}},
                     (state == S_CRE_A) ? cfg.origin_x : cfg.origin_y};
  assign re_sum   = {acc[PROD_W-1], acc} - {prod_fl[PROD_W-1], prod_fl};
  assign im_sum   = {acc[PROD_W-1], acc} + {prod_fl[PROD_W-1], prod_fl};
  assign sq_sum   = {1'b0, acc} + {1'b0, prod};
  assign addr_sum = {pr[WORD_W-1], pr} + {cr[WORD_W-1], cr};
  assign addi_sum = {pi[WORD_W-1], pi} + {ci[WORD_W-1], ci};

  assign count_inc = count + ITER_W'(1);
  assign mag_le    = mag <= MAG_W'(cfg.escape_sq);
  assign last_iter = count_inc == cfg.max_iter;
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  // Sequencer: next state and multiplier operand selection.
  always_comb begin
    state_next = state;
    mul_a      = pr;
    mul_b      = zr;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (cfg.max_iter == '0) ? S_DONE : S_CRE_M;
        end
      end
      S_CRE_M: begin
        mul_a      = cfg.step_x;
        mul_b      = WORD_W'(px);
        state_next = S_CRE_A;
      end
      S_CRE_A: state_next = S_CIM_M;
      S_CIM_M: begin
        mul_a      = cfg.step_y;
        mul_b      = WORD_W'(py);
        state_next = S_CIM_A;
      end
      S_CIM_A: state_next = S_ITER;
      S_ITER:  state_next = (p_eff == PW_BITS'(1)) ? S_ADDC : S_K0_M;
      S_K0_M: begin
        mul_a      = pr;
        mul_b      = zr;
        state_next = S_K0_A;
      end
      S_K0_A: state_next = S_K1_M;
      S_K1_M: begin
        mul_a      = pi;
        mul_b      = zi;
        state_next = S_K1_A;
      end
      S_K1_A: state_next = S_K2_M;
      S_K2_M: begin
        mul_a      = pr;
        mul_b      = zi;
        state_next = S_K2_A;
      end
      S_K2_A: state_next = S_K3_M;
      S_K3_M: begin
        mul_a      = pi;
        mul_b      = zr;
        state_next = S_K3_A;
      end
      S_K3_A: state_next = (kcnt == PW_BITS'(1)) ? S_ADDC : S_K0_M;
      S_ADDC: state_next = (outside && !extra) ? S_ITER : S_MAG0_M;
      S_MAG0_M: begin
        mul_a      = zr;
        mul_b      = zr;
        state_next = S_MAG0_A;
      end
      S_MAG0_A: state_next = S_MAG1_M;
      S_MAG1_M: begin
        mul_a      = zi;
        mul_b      = zi;
        state_next = S_MAG1_A;
      end
      S_MAG1_A: state_next = S_TEST;
      S_TEST: begin
        if (outside) begin
          state_next = S_DONE;
        end else if (mag_le) begin
          state_next = last_iter ? S_DONE : S_ITER;
        end else begin
          state_next = S_ITER;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register; a new result may be loaded as the old one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      iterations <= count;
      escaped    <= outside;
      if (!outside) begin
        final_mag_sq <= '0;
      end else if (|mag[MAG_W-1:WORD_W]) begin
        final_mag_sq <= '1;
      end else begin
        final_mag_sq <= mag[WORD_W-1:0];
      end
    end
  end

  // Datapath registers, updated by the state that owns each step.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          px      <= pixel_x;
          py      <= pixel_y;
          zr      <= '0;
          zi      <= '0;
          count   <= '0;
          outside <= 1'b0;
          extra   <= 1'b0;
          p_eff   <= p_clamp;
        end
      end
      S_CRE_A: cr <= sat32(c_sum);
      S_CIM_A: ci <= sat32(c_sum);
      S_ITER: begin
        pr   <= zr;
        pi   <= zi;
        kcnt <= p_eff - PW_BITS'(1);
      end
      S_K0_A: acc <= prod_fl;
      S_K1_A: tr  <= sat32(re_sum);
      S_K2_A: acc <= prod_fl;
      S_K3_A: begin
        pi   <= sat32(im_sum);
        pr   <= tr;
        kcnt <= kcnt - PW_BITS'(1);
      end
      S_ADDC: begin
        zr <= sat32({{(PROD_W-WORD_W){addr_sum[WORD_W]}}, addr_sum});
        zi <= sat32({{(PROD_W-WORD_W){addi_sum[WORD_W]}}, addi_sum});
        if (outside && !extra) begin
          extra <= 1'b1;
        end
      end
      S_MAG0_A: acc <= prod;
      S_MAG1_A: mag <= sq_sum[PROD_W:FRAC_BITS];
      S_TEST: begin
        if (!outside) begin
          if (mag_le) begin
            count <= count_inc;
          end else begin
            outside <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/mbrot_checker.sv =====
// Port-level checks of the escape-time pixel unit, bound to its top level.
`default_nettype none

module mbrot_checker
  import mbrot_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ITER_W-1:0] iterations,
  input wire logic              escaped,
  input wire logic [WORD_W-1:0] final_mag_sq
);

  // Only one pixel is in progress: a transfer in closes the input at once.
  a_one_at_a_time: assert property (
    @(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready
  ) else $error("input stayed ready after a transfer");

  // A stalled result keeps its value.
  a_result_holds: assert property (
    @(posedge clk) disable iff (rst) (out_valid && !out_ready) |=>
      (out_valid && $stable(iterations) && $stable(escaped) && $stable(final_mag_sq))
  ) else $error("stalled result changed or vanished");

  // A point that stayed inside reports no magnitude.
  a_inside_zero_mag: assert property (
    @(posedge clk) disable iff (rst) (out_valid && !escaped) |-> (final_mag_sq == '0)
  ) else $error("inside point with nonzero magnitude");

  // Reset leaves the unit idle with no result pending.
  a_reset_idle: assert property (
    @(posedge clk) rst |=> (!out_valid && in_ready)
  ) else $error("unit not idle after reset");

endmodule

bind mandelbrot_escape_time_pixel_unit mbrot_checker u_mbrot_checker (.*);

`default_nettype wire

// ===== dv/escape_time_checker.sv =====
// Checker for the escape-time pixel unit: watches all three channels and scores every result.
module escape_time_checker
  import mbrot_pkg::*;
#(
  parameter int MAX_POWER  = 8,
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 28
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [ITER_W-1:0]     iterations,
  input  logic                  escaped,
  input  logic [WORD_W-1:0]     final_mag_sq,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0]     cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output int                    results_seen,
  output int                    escapes_seen
);

  localparam int MAX_REPORTS = 30;

  // One predicted pixel result.
  typedef struct packed {
    logic [ITER_W-1:0] count;
    logic              outside;
    logic [WORD_W-1:0] mag;
  } pixel_result_t;

  // Own copy of the register file and the results still owed by the block.
  cfg_t          view_cfg;
  pixel_result_t owed_results[$];

  // Clamp to the signed 32-bit range.
  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Fixed-point product, rounded toward minus infinity.
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  // One iteration z = z^p + c, built from left-to-right complex products.
  function automatic void z_step(inout longint zr, inout longint zi,
                                 input longint cr, input longint ci, input int p);
    longint pr, pi, nr, ni;
    pr = zr;
    pi = zi;
    for (int k = 1; k < p; k++) begin
      nr = clamp_word(fx_mul(pr, zr) - fx_mul(pi, zi));
      ni = clamp_word(fx_mul(pr, zi) + fx_mul(pi, zr));
      pr = nr;
      pi = ni;
    end
    zr = clamp_word(pr + cr);
    zi = clamp_word(pi + ci);
  endfunction

  // Exact squared magnitude, floored to the fixed-point grid.
  function automatic logic [63:0] mag_sq(longint zr, longint zi);
    logic [63:0] ar, ai;
    ar = (zr < 0) ? -zr : zr;
    ai = (zi < 0) ? -zi : zi;
    return (ar * ar + ai * ai) >> FRAC_BITS;
  endfunction

  // Escape-time result of one pixel under the current registers.
  function automatic pixel_result_t predict_escape(logic [COORD_BITS-1:0] px,
                                                   logic [COORD_BITS-1:0] py);
    longint        cr, ci, zr, zi;
    int            p;
    int unsigned   count;
    bit            outside;
    logic [63:0]   m;
    pixel_result_t r;
    cr = clamp_word(longint'($signed(view_cfg.step_x)) * longint'(px)
                    + longint'($signed(view_cfg.origin_x)));
    ci = clamp_word(longint'($signed(view_cfg.step_y)) * longint'(py)
                    + longint'($signed(view_cfg.origin_y)));
    // A power of zero acts as one; anything above the ceiling is clamped.
    p = int'(view_cfg.power);
    if (p == 0) p = 1;
    if (p > MAX_POWER) p = MAX_POWER;
    zr = 0;
    zi = 0;
    count = 0;
    outside = 1'b0;
    while (count < view_cfg.max_iter) begin
      z_step(zr, zi, cr, ci, p);
      if (mag_sq(zr, zi) <= {32'd0, view_cfg.escape_sq}) begin
        count++;
      end else begin
        outside = 1'b1;
        break;
      end
    end
    r.count   = count[ITER_W-1:0];
    r.outside = outside;
    r.mag     = '0;
    // Escaped points run two more iterations before the magnitude is reported.
    if (outside) begin
      z_step(zr, zi, cr, ci, p);
      z_step(zr, zi, cr, ci, p);
      m = mag_sq(zr, zi);
      r.mag = (m > 64'hFFFF_FFFF) ? '1 : m[WORD_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatches++;
  endtask

  // Track register writes, predict on each input transfer, score each output transfer.
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst) begin
      view_cfg.step_x    = '0;
      view_cfg.step_y    = '0;
      view_cfg.origin_x  = '0;
      view_cfg.origin_y  = '0;
      view_cfg.escape_sq = 32'h4000_0000;
      view_cfg.max_iter  = 16'd256;
      view_cfg.power     = 4'd2;
      owed_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_STEP_X:    view_cfg.step_x    = cfg_data;
          CFG_STEP_Y:    view_cfg.step_y    = cfg_data;
          CFG_ORIGIN_X:  view_cfg.origin_x  = cfg_data;
          CFG_ORIGIN_Y:  view_cfg.origin_y  = cfg_data;
          CFG_ESCAPE_SQ: view_cfg.escape_sq = cfg_data;
          CFG_MAX_ITER:  view_cfg.max_iter  = cfg_data[ITER_W-1:0];
          CFG_POWER:     view_cfg.power     = cfg_data[POWER_W-1:0];
          default: ;
        endcase
      end
      // The result is scored before the new pixel is queued, so a result can
      // never be matched against the pixel accepted at the same edge.
      if (out_valid && out_ready) begin
        results_seen++;
        if (escaped) escapes_seen++;
        if (owed_results.size() == 0) begin
          report_mismatch("result transfer with no pixel outstanding");
        end else begin
          want = owed_results.pop_front();
          if (iterations !== want.count)
            report_mismatch($sformatf("iterations %0d, expected %0d", iterations, want.count));
          if (escaped !== want.outside)
            report_mismatch($sformatf("escaped %0b, expected %0b", escaped, want.outside));
          if (final_mag_sq !== want.mag)
            report_mismatch($sformatf("final_mag_sq %08h, expected %08h",
                                      final_mag_sq, want.mag));
        end
      end
      if (in_valid && in_ready) begin
        owed_results.push_back(predict_escape(pixel_x, pixel_y));
      end
      outstanding <= owed_results.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the escape-time pixel unit testbench: clock, reset, stimulus and verdict.
module testbench
  import mbrot_pkg::*;
();

  localparam int     COORD_BITS   = 12;
  localparam int     TOTAL_ITEMS  = 650;
  localparam int     IDLE_GAP     = 8;
  localparam int     LONG_HOLD    = 1500;
  localparam int     HOLD_PHASE   = 2;
  localparam longint TIMEOUT      = 64'd100_000_000;

  // Output-side stall patterns.
  typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COORD_BITS-1:0] pixel_x = '0;
  logic [COORD_BITS-1:0] pixel_y = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ITER_W-1:0]     iterations;
  logic                  escaped;
  logic [WORD_W-1:0]     final_mag_sq;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_STEP_X;
  logic [WORD_W-1:0]     cfg_data = '0;

  int mismatches, outstanding, results_seen, escapes_seen;

  // Sender bookkeeping.
  int items_sent = 0;
  int setups_loaded = 0;
  int burst_left = 0;
  bit offering = 1'b0;

  // Receiver bookkeeping; the stimulus asks for a long hold by toggling hold_tog.
  rx_mode_t rx_mode = RX_ALWAYS;
  int       mode_left = 0;
  int       hold_left = 0;
  bit       hold_tog = 1'b0;
  bit       hold_seen = 1'b0;

  mandelbrot_escape_time_pixel_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .out_valid(out_valid), .out_ready(out_ready), .iterations(iterations),
    .escaped(escaped), .final_mag_sq(final_mag_sq),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  escape_time_checker u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .out_valid(out_valid), .out_ready(out_ready), .iterations(iterations),
    .escaped(escaped), .final_mag_sq(final_mag_sq),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding),
    .results_seen(results_seen), .escapes_seen(escapes_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: a long hold when asked, otherwise a stall pattern that changes now and then.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      mode_left <= 0;
      hold_left <= 0;
      hold_seen <= hold_tog;
    end else if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(32, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_HALF:   out_ready <= ($urandom_range(0, 1) == 0);
        RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
        default:   out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Wait until every pixel has been answered, then let the block settle.
  task automatic wait_until_drained();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // Write all seven registers back to back while the block is idle.
  task automatic load_view(cfg_t s);
    logic [WORD_W-1:0] words [7];
    cfg_idx_t          idx;
    wait_until_drained();
    words[CFG_STEP_X]    = s.step_x;
    words[CFG_STEP_Y]    = s.step_y;
    words[CFG_ORIGIN_X]  = s.origin_x;
    words[CFG_ORIGIN_Y]  = s.origin_y;
    words[CFG_ESCAPE_SQ] = s.escape_sq;
    // Unused upper bits carry noise; the block keeps only the register width.
    words[CFG_MAX_ITER]  = {16'($urandom), s.max_iter};
    words[CFG_POWER]     = {28'($urandom), s.power};
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_index <= idx;
      cfg_data  <= words[idx];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
    setups_loaded++;
  endtask

  // Offer one pixel; bursts keep valid high across transfers, gaps follow each burst.
  task automatic offer_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    pixel_x  <= x;
    pixel_y  <= y;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
    offering = (burst_left != 0);
  endtask

  // Close the current burst in the step of the last transfer.
  task automatic close_stream();
    if (offering) in_valid <= 1'b0;
    offering = 1'b0;
    burst_left = 0;
  endtask

  // Random pixel with the edges of the frame now and then.
  task automatic offer_random_pixel();
    logic [COORD_BITS-1:0] x, y;
    x = COORD_BITS'($urandom);
    y = COORD_BITS'($urandom);
    if ($urandom_range(0, 7) == 0) x = $urandom_range(0, 1) ? '1 : '0;
    if ($urandom_range(0, 7) == 0) y = $urandom_range(0, 1) ? '1 : '0;
    offer_pixel(x, y);
  endtask

  // Classic view of the set: about 3 units across the frame.
  function automatic cfg_t classic_view();
    cfg_t s;
    s.step_x    = 32'd196608;
    s.step_y    = 32'd196608;
    s.origin_x  = 32'hE000_0000;
    s.origin_y  = 32'hE800_0000;
    s.escape_sq = 32'h4000_0000;
    s.max_iter  = 16'd32;
    s.power     = 4'd2;
    return s;
  endfunction

  // Random register set; iteration limits stay small so that slow pixels stay cheap.
  function automatic cfg_t random_view(bit wild);
    cfg_t s;
    int   p;
    s.power = ($urandom_range(0, 1) == 0) ? 4'd2 : 4'($urandom_range(0, 15));
    p = (s.power == 0) ? 1 : ((s.power > 8) ? 8 : s.power);
    if (wild) begin
      s.step_x    = $urandom;
      s.step_y    = $urandom;
      s.origin_x  = $urandom;
      s.origin_y  = $urandom;
      s.escape_sq = $urandom;
      s.max_iter  = (p <= 4) ? 16'($urandom_range(0, 12)) : 16'($urandom_range(0, 6));
    end else begin
      s.step_x    = $urandom_range(1 << 12, 1 << 18);
      s.step_y    = $urandom_range(1 << 12, 1 << 18);
      if ($urandom_range(0, 3) == 0) s.step_x = -s.step_x;
      if ($urandom_range(0, 3) == 0) s.step_y = -s.step_y;
      s.origin_x  = 32'hE000_0000 + $urandom_range(0, 32'h1800_0000);
      s.origin_y  = 32'hE800_0000 + $urandom_range(0, 32'h1000_0000);
      s.escape_sq = ($urandom_range(0, 3) != 0) ? 32'h4000_0000 : $urandom;
      s.max_iter  = (p <= 4) ? 16'($urandom_range(0, 16)) : 16'($urandom_range(0, 8));
    end
    return s;
  endfunction

  // Stimulus: directed corners first, then random register sets with random pixels.
  initial begin
    cfg_t s;
    int   phase;
    int   n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: c is zero everywhere, so both pixels stay inside.
    offer_pixel('0, '0);
    offer_pixel('1, '1);
    close_stream();

    // Classic view: a corner that escapes at once and points inside the set.
    s = classic_view();
    load_view(s);
    offer_pixel(12'd0, 12'd0);
    offer_pixel(12'd2730, 12'd2048);
    offer_pixel(12'd4095, 12'd0);
    offer_pixel(12'd1365, 12'd2048);
    close_stream();

    // Iteration limit of zero: nothing is iterated.
    s.max_iter = 16'd0;
    load_view(s);
    offer_pixel(12'd100, 12'd200);
    close_stream();

    // Power zero behaves as power one.
    s.max_iter = 16'd8;
    s.power    = 4'd0;
    load_view(s);
    offer_pixel(12'd2048, 12'd2048);
    offer_pixel(12'd0, 12'd4095);
    close_stream();

    // Power above the ceiling is clamped to it.
    s.power = 4'd15;
    load_view(s);
    offer_pixel(12'd2048, 12'd2048);
    offer_pixel(12'd2730, 12'd2048);
    close_stream();

    // Extreme steps and origins: c saturates and the final magnitude clips.
    s.step_x    = 32'h7FFF_FFFF;
    s.step_y    = 32'h8000_0000;
    s.origin_x  = 32'h7FFF_FFFF;
    s.origin_y  = 32'h8000_0000;
    s.escape_sq = 32'hFFFF_FFFF;
    s.max_iter  = 16'd4;
    s.power     = 4'd8;
    load_view(s);
    offer_pixel('1, '1);
    offer_pixel('0, '0);
    offer_pixel(12'd1, 12'd4095);
    close_stream();

    // Zero radius with the largest limit; c is never zero, so escape is immediate.
    s.step_x    = 32'h0001_0000;
    s.step_y    = 32'h0;
    s.origin_x  = 32'h0001_0000;
    s.origin_y  = 32'h0;
    s.escape_sq = 32'h0;
    s.max_iter  = 16'hFFFF;
    s.power     = 4'd2;
    load_view(s);
    offer_pixel('0, '0);
    offer_pixel('1, '1);
    close_stream();

    // Power one with a limit of one: a tiny c stays inside after one step.
    s.step_x    = 32'hFFFF_FFFF;
    s.step_y    = 32'h0000_0001;
    s.escape_sq = 32'hFFFF_FFFF;
    s.max_iter  = 16'd1;
    s.power     = 4'd1;
    load_view(s);
    offer_pixel('1, '1);
    close_stream();

    // The usual limit of 256 at power two over the classic view.
    s = classic_view();
    s.max_iter = 16'd256;
    load_view(s);
    repeat (20) offer_random_pixel();
    close_stream();

    // Random register sets until the pixel budget is used up.
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      s = random_view($urandom_range(0, 4) == 0);
      n = $urandom_range(10, 40);
      if (phase == HOLD_PHASE) begin
        // Cheap pixels under a long output hold fill the block and stall its input.
        s.max_iter = 16'd4;
        s.power    = 4'd2;
        n = 40;
      end
      load_view(s);
      if (phase == HOLD_PHASE) hold_tog <= ~hold_tog;
      repeat (n) offer_random_pixel();
      close_stream();
      phase++;
    end

    // Drain and watch a little longer for stray results.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Scored %0d pixel results (%0d escaped, %0d inside) over %0d register sets.",
             results_seen, escapes_seen, results_seen - escapes_seen, setups_loaded);
    $display("Covered powers 0 to 15, limits 0 to 65535, saturated c and one long output hold.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT);
    $display("testbench: FAIL");
    $finish;
  end

endmodule
